>>> design/ctfr_pkg.sv
// Package: shared constants, codes and transaction types of the clip transfer frame receiver.
package ctfr_pkg;

	localparam int unsigned DefMaxPayload = 32;
	localparam int unsigned HeaderBytes   = 5;
	localparam int unsigned PosW          = 7;
	localparam logic [PosW-1:0] PosMax    = 7'd127;
	localparam int unsigned CfgIdxW       = 2;
	localparam int unsigned CfgDataW      = 8;

	localparam logic [7:0] BeginOpReset = 8'd1;
	localparam logic [7:0] DataOpReset  = 8'd2;
	localparam logic [7:0] EndOpReset   = 8'd3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_BEGIN_OP = 2'd0,
		CFG_DATA_OP  = 2'd1,
		CFG_END_OP   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD    = 2'd1,
		ST_SINK   = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       first_of_frame;
		logic       last_of_frame;
		logic       sink_error;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  sink_data;
		logic        sink_data_valid;
		logic        open_clip;
		logic [7:0]  open_clip_id;
		logic [31:0] open_clip_length;
		logic        close_clip;
		logic [1:0]  frame_status;
		logic        status_valid;
		logic        clip_complete;
		logic        last_result;
	} out_item_t;

	function automatic out_item_t status_item(input status_t st, input logic open,
			input logic [7:0] id, input logic [31:0] len, input logic close,
			input logic done);
		out_item_t it;
		it                  = '0;
		it.open_clip        = open;
		it.open_clip_id     = open ? id : 8'd0;
		it.open_clip_length = open ? len : 32'd0;
		it.close_clip       = close;
		it.frame_status     = st;
		it.status_valid     = 1'b1;
		it.clip_complete    = done;
		it.last_result      = 1'b1;
		return it;
	endfunction

	function automatic out_item_t data_item(input logic [7:0] d);
		out_item_t it;
		it                 = '0;
		it.sink_data       = d;
		it.sink_data_valid = 1'b1;
		return it;
	endfunction

endpackage

>>> design/ctfr_stream_if.sv
// Interface: valid/ready stream channel carrying one payload transaction.
interface ctfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> design/clip_transfer_frame_receiver.sv
// Top level: clip transfer frame receiver with payload buffer and control.
//
// channel  | dir | transaction
// ---------+-----+----------------------------------------------------------
// frame    | in  | one frame byte with first/last marks and sink error flag
// result   | out | forwarded payload byte, or one status per completed frame
// cfg_*    | in  | opcode register write (begin, data, end), no read-back
//
// Cycles: one byte per cycle while the output register has room and no burst
// is under way. A forwarded DATA frame holds the input after its last byte for
// one buffer read setup, n bytes at one per cycle as the output has room, and
// one status, set by the single read port of the payload buffer.
// Reset: arst_n clears all control state; the buffer itself is not cleared,
// only entries written by the current frame are ever read back.
// Stalls: result.ready low holds the output register; frame.ready drops
// until the held transaction is taken.
module clip_transfer_frame_receiver #(
	parameter int unsigned MaxPayload = ctfr_pkg::DefMaxPayload
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ctfr_stream_if.sink                   frame,
	ctfr_stream_if.source                 result,
	input  logic                          cfg_we,
	input  logic [ctfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ctfr_pkg::CfgDataW-1:0] cfg_data
);
	import ctfr_pkg::*;

	// buffer address width; at least one bit for a single-entry buffer
	localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

	logic             buf_wr_en;
	logic [AddrW-1:0] buf_wr_addr;
	logic [7:0]       buf_wr_data;
	logic             buf_rd_en;
	logic [AddrW-1:0] buf_rd_addr;
	logic [7:0]       buf_rd_data;

	// bytes of the current frame, read back as a burst for a forwarded DATA frame
	ctfr_payload_buf #(
		.Depth (MaxPayload),
		.AddrW (AddrW)
	) u_buf (
		.clk     (clk),
		.wr_en   (buf_wr_en),
		.wr_addr (buf_wr_addr),
		.wr_data (buf_wr_data),
		.rd_en   (buf_rd_en),
		.rd_addr (buf_rd_addr),
		.rd_data (buf_rd_data)
	);

	// frame parsing, clip bookkeeping and the output register
	ctfr_ctrl #(
		.MaxPayload (MaxPayload),
		.AddrW      (AddrW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.buf_wr_en   (buf_wr_en),
		.buf_wr_addr (buf_wr_addr),
		.buf_wr_data (buf_wr_data),
		.buf_rd_en   (buf_rd_en),
		.buf_rd_addr (buf_rd_addr),
		.buf_rd_data (buf_rd_data)
	);
endmodule

>>> design/ctfr_payload_buf.sv
// Payload buffer: single write port, single read port, registered read data.
module ctfr_payload_buf #(
	parameter int unsigned Depth = 32,
	parameter int unsigned AddrW = 5
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [7:0]       rd_data
);
	logic [7:0] mem_q [Depth];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> design/ctfr_ctrl.sv
// Control: frame parsing, clip state, status decisions, burst readout and output register.
module ctfr_ctrl #(
	parameter int unsigned MaxPayload = ctfr_pkg::DefMaxPayload,
	parameter int unsigned AddrW      = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ctfr_stream_if.sink                   frame,
	ctfr_stream_if.source                 result,
	input  logic                          cfg_we,
	input  logic [ctfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ctfr_pkg::CfgDataW-1:0] cfg_data,
	output logic                          buf_wr_en,
	output logic [AddrW-1:0]              buf_wr_addr,
	output logic [7:0]                    buf_wr_data,
	output logic                          buf_rd_en,
	output logic [AddrW-1:0]              buf_rd_addr,
	input  logic [7:0]                    buf_rd_data
);
	import ctfr_pkg::*;

	localparam logic [PosW-1:0] MaxPos = PosW'(MaxPayload);
	localparam logic [PosW-1:0] HdrPos = PosW'(HeaderBytes);

	typedef enum logic [1:0] {
		S_RUN,
		S_BURST_RD,
		S_BURST_WR,
		S_STATUS
	} state_t;

	state_t          state_q;
	logic [7:0]      begin_op_q, data_op_q, end_op_q;
	logic            open_q, ovf_q, recv_q;
	logic [7:0]      op_q, id_q;
	logic [PosW-1:0] pos_q;
	logic [31:0]     len_q, exp_q, wc_q;
	logic [AddrW-1:0] cnt_q, burst_last_q;
	logic            out_valid_q;
	out_item_t       out_q;

	in_item_t        pin;
	logic            out_free, accept, take, done;
	logic            out_load;
	logic [7:0]      op_n, id_n;
	logic [PosW-1:0] pos_n;
	logic [31:0]     len_n;
	logic            ovf_n;

	// decision at the last byte
	status_t         d_status;
	logic            d_open, d_close, d_done, d_burst;
	logic            d_recv, d_load_clip, d_add;
	logic            overrun;

	assign pin      = frame.payload;
	assign out_free = !out_valid_q || result.ready;
	assign frame.ready = (state_q == S_RUN) && out_free;
	assign accept   = frame.valid && frame.ready;
	assign take     = accept && (pin.first_of_frame || open_q);
	assign done     = take && pin.last_of_frame;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// output register takes a new transaction this cycle
	assign out_load = ((state_q == S_RUN) && done && !d_burst) ||
		(((state_q == S_BURST_WR) || (state_q == S_STATUS)) && out_free);

	assign buf_wr_en   = accept && !pin.first_of_frame && open_q && (pos_q < MaxPos);
	assign buf_wr_addr = pos_q[AddrW-1:0];
	assign buf_wr_data = pin.frame_byte;

	assign buf_rd_en   = (state_q == S_BURST_RD) ||
		((state_q == S_BURST_WR) && out_free && (cnt_q != burst_last_q));
	assign buf_rd_addr = (state_q == S_BURST_RD) ? '0 : cnt_q + 1'b1;

	always_comb begin
		if (pin.first_of_frame) begin
			op_n  = pin.frame_byte;
			pos_n = '0;
			id_n  = '0;
			len_n = '0;
			ovf_n = 1'b0;
		end else begin
			op_n  = op_q;
			pos_n = (pos_q < PosMax) ? pos_q + 1'b1 : pos_q;
			id_n  = (pos_q == '0) ? pin.frame_byte : id_q;
			len_n = len_q;
			for (int k = 0; k < 4; k++) begin
				if (pos_q == PosW'(k + 1)) begin
					len_n[8*k +: 8] = pin.frame_byte;
				end
			end
			ovf_n = ovf_q || (pos_q >= MaxPos);
		end
	end

	assign overrun = ({1'b0, wc_q} + 33'(pos_n)) > {1'b0, exp_q};

	always_comb begin
		d_status    = ST_BAD;
		d_open      = 1'b0;
		d_close     = 1'b0;
		d_done      = 1'b0;
		d_burst     = 1'b0;
		d_recv      = recv_q;
		d_load_clip = 1'b0;
		d_add       = 1'b0;
		// begin wins over data, data over end when opcodes collide
		if (op_n == begin_op_q) begin
			if (pos_n >= HdrPos) begin
				d_open = 1'b1;
				if (pin.sink_error) begin
					d_status = ST_REJECT;
					d_recv   = 1'b0;
				end else begin
					d_status    = ST_OK;
					d_recv      = 1'b1;
					d_load_clip = 1'b1;
				end
			end
		end else if (op_n == data_op_q) begin
			if (recv_q) begin
				if (ovf_n) begin
					d_status = ST_REJECT;
					d_recv   = 1'b0;
				end else if (pos_n == '0) begin
					d_status = ST_OK;
				end else if (overrun) begin
					d_status = ST_REJECT;
					d_recv   = 1'b0;
				end else if (pin.sink_error) begin
					d_status = ST_SINK;
					d_recv   = 1'b0;
				end else begin
					d_status = ST_OK;
					d_burst  = 1'b1;
					d_add    = 1'b1;
				end
			end
		end else if (op_n == end_op_q) begin
			if (recv_q) begin
				d_recv = 1'b0;
				if (wc_q != exp_q) begin
					d_status = ST_BAD;
				end else if (pin.sink_error) begin
					d_status = ST_SINK;
					d_close  = 1'b1;
				end else begin
					d_status = ST_OK;
					d_close  = 1'b1;
					d_done   = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_RUN;
			begin_op_q   <= BeginOpReset;
			data_op_q    <= DataOpReset;
			end_op_q     <= EndOpReset;
			open_q       <= 1'b0;
			ovf_q        <= 1'b0;
			recv_q       <= 1'b0;
			op_q         <= '0;
			id_q         <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			exp_q        <= '0;
			wc_q         <= '0;
			cnt_q        <= '0;
			burst_last_q <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BEGIN_OP: begin_op_q <= cfg_data;
					CFG_DATA_OP:  data_op_q  <= cfg_data;
					CFG_END_OP:   end_op_q   <= cfg_data;
					default: ;
				endcase
			end

			if (result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_RUN: begin
					if (take) begin
						op_q   <= op_n;
						id_q   <= id_n;
						pos_q  <= pos_n;
						len_q  <= len_n;
						ovf_q  <= ovf_n;
						open_q <= !pin.last_of_frame;
					end
					if (done) begin
						recv_q <= d_recv;
						if (d_load_clip) begin
							exp_q <= len_n;
							wc_q  <= '0;
						end
						if (d_add) begin
							wc_q <= wc_q + 32'(pos_n);
						end
						if (d_burst) begin
							burst_last_q <= AddrW'(pos_n - 1'b1);
							state_q      <= S_BURST_RD;
						end else begin
							out_q       <= status_item(d_status, d_open, id_n, len_n,
								d_close, d_done);
							out_valid_q <= 1'b1;
						end
					end
				end
				S_BURST_RD: begin
					cnt_q   <= '0;
					state_q <= S_BURST_WR;
				end
				S_BURST_WR: begin
					if (out_free) begin
						out_q       <= data_item(buf_rd_data);
						out_valid_q <= 1'b1;
						if (cnt_q == burst_last_q) begin
							state_q <= S_STATUS;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_STATUS: begin
					if (out_free) begin
						out_q       <= status_item(ST_OK, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0);
						out_valid_q <= 1'b1;
						state_q     <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end
endmodule
